@@ rtl/tftp_read_receiver_top_defines.svh @@
// ----------------------------------------------------------------------------
// tftp_read_receiver_top_defines
// Assertion macros shared by the queue and back-end modules.
// ----------------------------------------------------------------------------
`ifndef TFTP_READ_RECEIVER_TOP_DEFINES_SVH
`define TFTP_READ_RECEIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define TFTPRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// trigger followed in the next cycle by a consequence
`define TFTPRR_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);
`else
`define TFTPRR_ASSERT(label, prop, msg)
`define TFTPRR_ASSERT_NEXT(label, trig, prop, msg)
`endif

`endif

@@ rtl/tftprr_pkg.sv @@
// ----------------------------------------------------------------------------
// tftprr_pkg
// Types and constants of the TFTP read receiver.
// ----------------------------------------------------------------------------
package tftprr_pkg;

  localparam int BLOCK_BYTES = 512;

  localparam int POS_W  = $clog2(BLOCK_BYTES + 5);
  localparam int DCNT_W = $clog2(BLOCK_BYTES + 1);

  localparam logic [POS_W-1:0]  POS_MAX    = POS_W'(BLOCK_BYTES + 4);
  localparam logic [POS_W-1:0]  POS_OPCODE = POS_W'(2);
  localparam logic [POS_W-1:0]  POS_HEADER = POS_W'(4);
  localparam logic [DCNT_W-1:0] DCNT_FULL  = DCNT_W'(BLOCK_BYTES);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_BEGIN = 1'b1;

  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [7:0]  OP_ACK   = 8'd4;

  localparam logic [15:0] FIRST_BLOCK = 16'd1;

  typedef enum logic [1:0] {
    PH_ACTIVE = 2'd0,
    PH_DONE   = 2'd1,
    PH_HALTED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_DONE        = 3'd1,
    ST_WRONG_BLOCK = 3'd2,
    ST_ERROR       = 3'd3,
    ST_BAD         = 3'd4,
    ST_INACTIVE    = 3'd5
  } status_t;

  // work for the back end: an optional data byte, then at packet end an
  // optional ack and a status
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data;
    logic        eop;
    logic        has_ack;
    logic [15:0] block;
    status_t     status;
  } job_t;

endpackage

@@ rtl/tftprr_if.sv @@
// ----------------------------------------------------------------------------
// tftprr_in_if / tftprr_out_if
// Valid/ready channels for received bytes and for results.
// ----------------------------------------------------------------------------
interface tftprr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, action, packet_byte, end_of_packet, input ready);
  modport sink (input valid, action, packet_byte, end_of_packet, output ready);
endinterface

interface tftprr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last_of_run;

  modport source (output valid, kind, out_byte, status, last_of_run, input ready);
  modport sink (input valid, kind, out_byte, status, last_of_run, output ready);
endinterface

@@ rtl/tftprr_front.sv @@
// ----------------------------------------------------------------------------
// tftprr_front
// Parses packet bytes, tracks the transfer and queues work for the back end.
// ----------------------------------------------------------------------------
module tftprr_front (
  input  logic               clk,
  input  logic               rst,
  tftprr_in_if.sink          in_ch,
  input  logic               q_full,
  output logic               push,
  output tftprr_pkg::job_t   job
);
  import tftprr_pkg::*;

  phase_t             phase, phase_next;
  logic [15:0]        expected_block;
  logic [POS_W-1:0]   byte_position;
  logic [15:0]        opcode_seen;
  logic [15:0]        block_seen;
  logic [DCNT_W-1:0]  data_count;

  logic               acc;
  logic [POS_W-1:0]   pos_n;
  logic [15:0]        op_n;
  logic [15:0]        blk_n;
  logic [DCNT_W-1:0]  dc_n;
  logic               fwd;
  status_t            pkt_status;
  logic               send_ack;
  logic               halt;
  logic               finish;
  logic               bump;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;

  // absorb the byte and classify the packet as it would stand at its end
  always_comb begin
    op_n       = opcode_seen;
    blk_n      = block_seen;
    dc_n       = data_count;
    fwd        = 1'b0;
    pkt_status = ST_OK;
    send_ack   = 1'b0;
    halt       = 1'b0;
    finish     = 1'b0;
    bump       = 1'b0;
    if (byte_position < POS_OPCODE) begin
      op_n = {opcode_seen[7:0], in_ch.packet_byte};
    end else if (byte_position < POS_HEADER) begin
      blk_n = {block_seen[7:0], in_ch.packet_byte};
    end else if (opcode_seen == OP_DATA && block_seen == expected_block &&
                 data_count < DCNT_FULL) begin
      fwd  = 1'b1;
      dc_n = data_count + DCNT_W'(1);
    end
    pos_n = (byte_position < POS_MAX) ? byte_position + POS_W'(1) : byte_position;

    if (pos_n < POS_OPCODE) begin
      pkt_status = ST_BAD;
    end else if (op_n == OP_ERROR) begin
      pkt_status = ST_ERROR;
      halt       = 1'b1;
    end else if (op_n != OP_DATA) begin
      pkt_status = ST_BAD;
      halt       = 1'b1;
    end else if (pos_n < POS_HEADER) begin
      pkt_status = ST_BAD;
    end else if (blk_n != expected_block) begin
      pkt_status = ST_WRONG_BLOCK;
    end else begin
      send_ack = 1'b1;
      if (dc_n < DCNT_FULL) begin
        pkt_status = ST_DONE;
        finish     = 1'b1;
      end else begin
        pkt_status = ST_OK;
        bump       = 1'b1;
      end
    end
  end

  // transfer phase
  always_comb begin
    phase_next = phase;
    if (acc) begin
      if (in_ch.action == ACT_BEGIN) begin
        phase_next = PH_ACTIVE;
      end else begin
        unique case (phase)
          PH_ACTIVE: begin
            if (in_ch.end_of_packet && halt) begin
              phase_next = PH_HALTED;
            end else if (in_ch.end_of_packet && finish) begin
              phase_next = PH_DONE;
            end
          end
          PH_DONE:   phase_next = PH_DONE;
          PH_HALTED: phase_next = PH_HALTED;
          default:   phase_next = PH_HALTED;
        endcase
      end
    end
  end

  // work handed to the back end
  always_comb begin
    push         = 1'b0;
    job.has_data = fwd;
    job.data     = in_ch.packet_byte;
    job.eop      = in_ch.end_of_packet;
    job.has_ack  = in_ch.end_of_packet && send_ack;
    job.block    = expected_block;
    job.status   = pkt_status;
    if (acc && in_ch.action == ACT_BYTE) begin
      if (phase != PH_ACTIVE) begin
        push         = in_ch.end_of_packet;
        job.has_data = 1'b0;
        job.has_ack  = 1'b0;
        job.status   = ST_INACTIVE;
      end else begin
        push = fwd || in_ch.end_of_packet;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ACTIVE;
      expected_block <= FIRST_BLOCK;
      byte_position  <= '0;
      opcode_seen    <= '0;
      block_seen     <= '0;
      data_count     <= '0;
    end else begin
      phase <= phase_next;
      if (acc) begin
        if (in_ch.action == ACT_BEGIN) begin
          expected_block <= FIRST_BLOCK;
          byte_position  <= '0;
          opcode_seen    <= '0;
          block_seen     <= '0;
          data_count     <= '0;
        end else if (phase != PH_ACTIVE || in_ch.end_of_packet) begin
          if (in_ch.end_of_packet) begin
            byte_position <= '0;
            opcode_seen   <= '0;
            block_seen    <= '0;
            data_count    <= '0;
          end
          if (phase == PH_ACTIVE && in_ch.end_of_packet && bump) begin
            expected_block <= expected_block + 16'd1;
          end
        end else begin
          byte_position <= pos_n;
          opcode_seen   <= op_n;
          block_seen    <= blk_n;
          data_count    <= dc_n;
        end
      end
    end
  end

endmodule

@@ rtl/tftprr_queue.sv @@
// ----------------------------------------------------------------------------
// tftprr_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "tftp_read_receiver_top_defines.svh"

module tftprr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tftprr_pkg::job_t push_job,
  output logic             full,
  input  logic             pop,
  output tftprr_pkg::job_t head,
  output logic             empty
);
  import tftprr_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `TFTPRR_ASSERT(a_no_overflow, !(push && full), "push into a full queue")
  `TFTPRR_ASSERT(a_no_underflow, !(pop && empty), "pop from an empty queue")
  `TFTPRR_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + QCNT_W'(1),
    "queue count did not grow on push")
endmodule

@@ rtl/tftprr_back.sv @@
// ----------------------------------------------------------------------------
// tftprr_back
// Expands queued jobs into result beats through an output register.
// ----------------------------------------------------------------------------
`include "tftp_read_receiver_top_defines.svh"

module tftprr_back (
  input  logic             clk,
  input  logic             rst,
  input  tftprr_pkg::job_t head,
  input  logic             empty,
  output logic             pop,
  tftprr_out_if.source     out_ch
);
  import tftprr_pkg::*;

  localparam logic [2:0] STEP_DATA   = 3'd0;
  localparam logic [2:0] STEP_ACK0   = 3'd1;
  localparam logic [2:0] STEP_ACK1   = 3'd2;
  localparam logic [2:0] STEP_ACK2   = 3'd3;
  localparam logic [2:0] STEP_ACK3   = 3'd4;
  localparam logic [2:0] STEP_STATUS = 3'd5;

  logic [2:0] step;
  logic [2:0] cur;
  logic       last_res;
  logic       load;
  kind_t      res_kind;
  logic [7:0] res_byte;
  status_t    res_status;

  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte_q;
  logic [2:0] out_status;
  logic       out_last;

  // skip parts of the job that are absent
  always_comb begin
    cur = step;
    if (cur == STEP_DATA && !head.has_data) begin
      cur = STEP_ACK0;
    end
    if (cur >= STEP_ACK0 && cur <= STEP_ACK3 && !head.has_ack) begin
      cur = STEP_STATUS;
    end
    last_res = (cur == STEP_STATUS) || (cur == STEP_DATA && !head.eop);
  end

  always_comb begin
    res_kind   = KIND_ACK;
    res_byte   = 8'd0;
    res_status = ST_OK;
    case (cur)
      STEP_DATA: begin
        res_kind = KIND_DATA;
        res_byte = head.data;
      end
      STEP_ACK0: res_byte = 8'd0;
      STEP_ACK1: res_byte = OP_ACK;
      STEP_ACK2: res_byte = head.block[15:8];
      STEP_ACK3: res_byte = head.block[7:0];
      default: begin
        res_kind   = KIND_STATUS;
        res_status = head.status;
      end
    endcase
  end

  assign load = (!out_valid || out_ch.ready) && !empty;
  assign pop  = load && last_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_DATA;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= last_res ? STEP_DATA : cur + 3'd1;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= res_kind;
      out_byte_q <= res_byte;
      out_status <= res_status;
      out_last   <= last_res;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = out_kind;
  assign out_ch.out_byte    = out_byte_q;
  assign out_ch.status      = out_status;
  assign out_ch.last_of_run = out_last;

  `TFTPRR_ASSERT(a_step_range, step <= STEP_STATUS, "step past the status beat")
  `TFTPRR_ASSERT_NEXT(a_pop_restarts, pop, step == STEP_DATA,
    "step not rewound after a finished job")
  `TFTPRR_ASSERT_NEXT(a_status_last, load && cur == STEP_STATUS,
    out_ch.last_of_run && out_ch.valid, "status beat not marked last")
endmodule

@@ rtl/tftp_read_receiver_top.sv @@
// ----------------------------------------------------------------------------
// tftp_read_receiver_top
// Receive side of an octet-mode TFTP read transfer.
// ----------------------------------------------------------------------------
// in_ch carries one received packet byte per beat with an end_of_packet flag,
// or a begin action that restarts the transfer expecting block 1.
// out_ch carries results: file data bytes of the expected block, the four
// ack bytes at the end of an accepted block, and one status per packet end;
// last_of_run marks the final result caused by one input beat.
// An accepted beat is written into the job queue, and its results are
// then loaded into the output register. Throughput: one input beat per cycle
// while in_ch.ready is high. Data bytes give one result each; a packet end
// gives up to six, one per cycle from the output stage while out_ch is ready.
// A four-entry job queue between parser and output stage absorbs these
// bursts; in_ch.ready drops only while that queue is full.
// Reset: expects block 1, transfer active, queue empty, no result pending.
// When the receiver stalls out_ch, the current result holds in the output
// register, the queue fills and then in_ch is held off.
// ----------------------------------------------------------------------------
module tftp_read_receiver_top (
  input  logic         clk,
  input  logic         rst,
  tftprr_in_if.sink    in_ch,
  tftprr_out_if.source out_ch
);
  import tftprr_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head;

  tftprr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  tftprr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  tftprr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
